### rtl/core/sle_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sequential list engine.
package sle_pkg;

    localparam int CAPACITY = 128;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int ADDR_W   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_FIND   = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] list_length;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_cmd_t;

endpackage

### rtl/core/sle_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read per cycle.
module sle_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/sle_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer: length count, shift and search walks over the element RAM.
module sle_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sle_pkg::req_t                 request,
    output logic                          done,
    output sle_pkg::rsp_t                 result,
    output sle_pkg::mem_cmd_t             mem_cmd,
    input  logic [sle_pkg::DATA_W-1:0]    mem_rdata
);

    localparam int AW  = sle_pkg::ADDR_W;
    localparam int CW  = sle_pkg::CNT_W;
    localparam int PW  = sle_pkg::CMP_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_DEL  = 2'd2;
    localparam logic [1:0] S_FIND = 2'd3;

    logic [1:0]          state_reg, state_next;
    sle_pkg::req_t       req_reg, req_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       la_reg, la_next;
    logic                rv_reg, rv_next;
    logic                end_reg, end_next;
    logic                done_reg, done_next;
    sle_pkg::rsp_t       rsp_reg, rsp_next;

    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       cnt_ext;
    logic                full;
    logic                pos_bad;
    logic [AW-1:0]       pos_addr;
    logic [AW-1:0]       held_pos_addr;
    logic [AW-1:0]       last_addr;

    always_comb
    begin
        pos_ext       = PW'(request.position);
        cnt_ext       = PW'(count_reg);
        full          = (count_reg >= CW'(sle_pkg::CAPACITY));
        pos_bad       = (pos_ext == '0) || (pos_ext > cnt_ext);
        pos_addr      = AW'(pos_ext);
        held_pos_addr = AW'(PW'(req_reg.position) - PW'(1));
        last_addr     = AW'(count_reg - CW'(1));
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        la_next    = la_reg;
        rv_next    = 1'b0;
        end_next   = end_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_cmd       = '0;
        mem_cmd.raddr = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    end_next = 1'b0;
                    rsp_next = '0;
                    case (request.op)
                        sle_pkg::OP_APPEND:
                        begin
                            done_next = 1'b1;
                            if (!full)
                            begin
                                mem_cmd.we    = 1'b1;
                                mem_cmd.waddr = AW'(count_reg);
                                mem_cmd.wdata = $unsigned(request.value);
                                count_next    = count_reg + CW'(1);
                                rsp_next.ok   = 1'b1;
                            end
                        end
                        sle_pkg::OP_INSERT:
                        begin
                            if (full || pos_bad)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = last_addr;
                                state_next = S_INS;
                            end
                        end
                        sle_pkg::OP_DELETE:
                        begin
                            if (pos_bad)
                            begin
                                done_next = 1'b1;
                            end
                            else if (pos_ext == cnt_ext)
                            begin
                                // tail entry: nothing to move
                                count_next  = count_reg - CW'(1);
                                rsp_next.ok = 1'b1;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                idx_next   = pos_addr;
                                state_next = S_DEL;
                            end
                        end
                        sle_pkg::OP_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                // walk down: write lands one above the entry read last cycle
                if (rv_reg)
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = la_reg + AW'(1);
                    mem_cmd.wdata = mem_rdata;
                end
                if (!end_reg)
                begin
                    rv_next = 1'b1;
                    la_next = idx_reg;
                    if (idx_reg == held_pos_addr)
                        end_next = 1'b1;
                    else
                        idx_next = idx_reg - AW'(1);
                end
                else if (!rv_reg)
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = held_pos_addr;
                    mem_cmd.wdata = $unsigned(req_reg.value);
                    count_next    = count_reg + CW'(1);
                    rsp_next.ok   = 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_DEL:
            begin
                // walk up: write lands one below the entry read last cycle
                if (rv_reg)
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = la_reg - AW'(1);
                    mem_cmd.wdata = mem_rdata;
                end
                if (!end_reg)
                begin
                    rv_next = 1'b1;
                    la_next = idx_reg;
                    if (idx_reg == last_addr)
                        end_next = 1'b1;
                    else
                        idx_next = idx_reg + AW'(1);
                end
                if (rv_reg && end_reg)
                begin
                    count_next  = count_reg - CW'(1);
                    rsp_next.ok = 1'b1;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_FIND:
            begin
                if (!end_reg)
                begin
                    rv_next = 1'b1;
                    la_next = idx_reg;
                    if (idx_reg == last_addr)
                        end_next = 1'b1;
                    else
                        idx_next = idx_reg + AW'(1);
                end
                if (rv_reg)
                begin
                    if (mem_rdata == $unsigned(req_reg.value))
                    begin
                        rsp_next.ok             = 1'b1;
                        rsp_next.found_position =
                            sle_pkg::POS_W'((AW + 1)'(la_reg) + (AW + 1)'(1));
                        done_next  = 1'b1;
                        rv_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (end_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            rsp_next.list_length = sle_pkg::POS_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
            end_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
            end_reg   <= end_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        idx_reg <= idx_next;
        la_reg  <= la_next;
        rsp_reg <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(sle_pkg::CAPACITY))
        else $error("list length above capacity");

    a_count_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> done_reg)
        else $error("length changed without a result");

    a_length_reported: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rsp_reg.list_length == sle_pkg::POS_W'(count_reg)))
        else $error("reported length differs from count");

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_cmd.we |-> ({1'b0, mem_cmd.waddr} < (AW + 1)'(sle_pkg::CAPACITY)))
        else $error("write beyond capacity");

    a_find_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && start && request.op == sle_pkg::OP_FIND && count_reg != '0)
        |=> (state_reg == S_FIND))
        else $error("find on nonempty list did not start a walk");
`endif

endmodule

### rtl/core/sequential_list_engine.sv
`timescale 1ns / 1ps
// Top level of the sequential list engine: sequencer plus element RAM.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------
//  request   | start, busy        | request (op, position, value)
//  result    | done (1-cycle)     | result (ok, found_position, list_length)
//
// Append, tail delete and requests rejected at the start: result strobes in the
// cycle after the transfer. Find: one RAM read per cycle from the first entry to
// a match or the last entry. Insert and delete shift entries one a cycle through
// the single RAM read port and single write port, from the position to the tail.
// Reset clears the length and the sequencer state; RAM contents are not cleared.
// busy stays high during a walk; the result strobe cannot be stalled.
module sequential_list_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sle_pkg::req_t request,
    output logic          done,
    output sle_pkg::rsp_t result
);

    sle_pkg::mem_cmd_t                mem_cmd;
    logic [sle_pkg::DATA_W-1:0]       mem_rdata;

    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .mem_cmd   (mem_cmd),
        .mem_rdata (mem_rdata)
    );

    sle_ram #(
        .DEPTH (sle_pkg::CAPACITY),
        .WIDTH (sle_pkg::DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.waddr),
        .wdata (mem_cmd.wdata),
        .raddr (mem_cmd.raddr),
        .rdata (mem_rdata)
    );

endmodule
